// File: hdl/mmae_pkg.sv
package mmae_pkg;

  localparam int unsigned IDX_W  = 3;            // row / column index width
  localparam int unsigned ADDR_W = 2 * IDX_W;    // store address {row, col}
  localparam int unsigned DIM_W  = 4;            // dimension register width
  localparam int unsigned DATA_W = 32;           // Q16.16 element
  localparam int unsigned PROD_W = 2 * DATA_W;   // Q32.32 product
  localparam int unsigned ACC_W  = PROD_W + 3;   // eight products without overflow
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned TDATA_W = 40;          // row, col, value padded to bytes
  localparam logic [DIM_W-1:0] MAX_DIM = 4'd8;

  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_MUL    = 2'd2,
    FUNC_ADD    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              first;
    logic              is_add;
    logic              load_out;
    logic              out_err;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic              out_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// File: hdl/mmae_ctrl.sv
module mmae_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [mmae_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         in_func_i,
  input  logic [mmae_pkg::IDX_W-1:0]         in_row_i,
  input  logic [mmae_pkg::IDX_W-1:0]         in_col_i,
  input  mmae_pkg::dp_sts_t                  sts_i,
  output mmae_pkg::ctl_cmd_t                 cmd_o
);

  mmae_pkg::state_e state_q, state_d;

  logic [mmae_pkg::DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [mmae_pkg::IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic                       wcnt_q, wcnt_d;
  logic                       err_q, err_d;
  logic                       is_add_q, is_add_d;

  logic [mmae_pkg::IDX_W-1:0] ar_m1, ac_m1, br_m1, bc_m1, j_m1;
  logic                       accept, last_k, last_elem, mismatch;
  mmae_pkg::func_e            func;

  // 0 acts as 1, above MAX_DIM acts as MAX_DIM; returns dimension minus one
  function automatic logic [mmae_pkg::IDX_W-1:0] dim_m1(
      input logic [mmae_pkg::DIM_W-1:0] r);
    logic [mmae_pkg::DIM_W-1:0] v;
    begin
      if (r == '0) begin
        v = 4'd1;
      end else if (r > mmae_pkg::MAX_DIM) begin
        v = mmae_pkg::MAX_DIM;
      end else begin
        v = r;
      end
      dim_m1 = mmae_pkg::IDX_W'(v - 4'd1);
    end
  endfunction

  assign ar_m1 = dim_m1(a_rows_q);
  assign ac_m1 = dim_m1(a_cols_q);
  assign br_m1 = dim_m1(b_rows_q);
  assign bc_m1 = dim_m1(b_cols_q);
  assign j_m1  = is_add_q ? ac_m1 : bc_m1;

  assign func      = mmae_pkg::func_e'(in_func_i);
  assign accept    = in_valid_i && in_ready_o;
  assign last_k    = is_add_q || (k_q == ac_m1);
  assign last_elem = err_q || ((i_q == ar_m1) && (j_q == j_m1));

  always_comb begin
    case (func)
      mmae_pkg::FUNC_MUL: mismatch = (ac_m1 != br_m1);
      mmae_pkg::FUNC_ADD: mismatch = (ar_m1 != br_m1) || (ac_m1 != bc_m1);
      default:            mismatch = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= mmae_pkg::MAX_DIM;
      a_cols_q <= mmae_pkg::MAX_DIM;
      b_rows_q <= mmae_pkg::MAX_DIM;
      b_cols_q <= mmae_pkg::MAX_DIM;
    end else if (cfg_we_i) begin
      case (mmae_pkg::reg_idx_e'(cfg_idx_i))
        mmae_pkg::REG_A_ROWS: a_rows_q <= cfg_data_i;
        mmae_pkg::REG_A_COLS: a_cols_q <= cfg_data_i;
        mmae_pkg::REG_B_ROWS: b_rows_q <= cfg_data_i;
        mmae_pkg::REG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmae_pkg::ST_IDLE: begin
        if (accept && (func == mmae_pkg::FUNC_MUL || func == mmae_pkg::FUNC_ADD)) begin
          state_d = mismatch ? mmae_pkg::ST_EMIT : mmae_pkg::ST_ISSUE;
        end
      end
      mmae_pkg::ST_ISSUE: begin
        if (last_k) begin
          state_d = mmae_pkg::ST_WAIT;
        end
      end
      mmae_pkg::ST_WAIT: begin
        if (wcnt_q) begin
          state_d = mmae_pkg::ST_EMIT;
        end
      end
      mmae_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = last_elem ? mmae_pkg::ST_IDLE : mmae_pkg::ST_ISSUE;
        end
      end
      default: state_d = mmae_pkg::ST_IDLE;
    endcase
  end

  // counters and command flags
  always_comb begin
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    wcnt_d   = 1'b0;
    err_d    = err_q;
    is_add_d = is_add_q;
    case (state_q)
      mmae_pkg::ST_IDLE: begin
        if (accept) begin
          i_d      = '0;
          j_d      = '0;
          k_d      = '0;
          err_d    = mismatch;
          is_add_d = (func == mmae_pkg::FUNC_ADD);
        end
      end
      mmae_pkg::ST_ISSUE: begin
        k_d = k_q + 3'd1;
      end
      mmae_pkg::ST_WAIT: begin
        wcnt_d = 1'b1;
      end
      mmae_pkg::ST_EMIT: begin
        k_d = '0;
        if (sts_i.out_free && !last_elem) begin
          if (j_q == j_m1) begin
            j_d = '0;
            i_d = i_q + 3'd1;
          end else begin
            j_d = j_q + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = (state_q == mmae_pkg::ST_IDLE);
    cmd_o          = '0;
    cmd_o.wr_addr  = {in_row_i, in_col_i};
    cmd_o.is_add   = is_add_q;
    cmd_o.out_err  = err_q;
    cmd_o.out_row  = i_q;
    cmd_o.out_col  = j_q;
    cmd_o.out_last = last_elem;
    cmd_o.first    = (k_q == '0);
    cmd_o.a_addr   = is_add_q ? {i_q, j_q} : {i_q, k_q};
    cmd_o.b_addr   = is_add_q ? {i_q, j_q} : {k_q, j_q};
    case (state_q)
      mmae_pkg::ST_IDLE: begin
        cmd_o.we_a = accept && (func == mmae_pkg::FUNC_LOAD_A);
        cmd_o.we_b = accept && (func == mmae_pkg::FUNC_LOAD_B);
      end
      mmae_pkg::ST_ISSUE: cmd_o.rd_en    = 1'b1;
      mmae_pkg::ST_EMIT:  cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mmae_pkg::ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      wcnt_q   <= 1'b0;
      err_q    <= 1'b0;
      is_add_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      wcnt_q   <= wcnt_d;
      err_q    <= err_d;
      is_add_q <= is_add_d;
    end
  end

endmodule

// File: hdl/mmae_datapath.sv
module mmae_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mmae_pkg::ctl_cmd_t                cmd_i,
  output mmae_pkg::dp_sts_t                 sts_o,
  input  logic [mmae_pkg::DATA_W-1:0]       wr_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mmae_pkg::IDX_W-1:0]        out_row_o,
  output logic [mmae_pkg::IDX_W-1:0]        out_col_o,
  output logic [mmae_pkg::DATA_W-1:0]       out_value_o,
  output logic                              out_last_o,
  output logic                              out_status_o
);

  localparam int unsigned DEPTH = 2 ** mmae_pkg::ADDR_W;
  localparam int unsigned SAT_W = mmae_pkg::ACC_W - mmae_pkg::FRAC_W - mmae_pkg::DATA_W + 1;

  logic [mmae_pkg::DATA_W-1:0] a_mem [DEPTH];
  logic [mmae_pkg::DATA_W-1:0] b_mem [DEPTH];

  logic signed [mmae_pkg::DATA_W-1:0] a_rd_q, b_rd_q;
  logic                               s1_vld_q, s1_first_q;
  logic                               s2_vld_q, s2_first_q;
  logic signed [mmae_pkg::ACC_W-1:0]  term_q, term_d, acc_q;
  logic signed [mmae_pkg::PROD_W-1:0] prod;
  logic signed [mmae_pkg::DATA_W:0]   sum;

  logic                        out_vld_q;
  logic [mmae_pkg::IDX_W-1:0]  out_row_q, out_col_q;
  logic [mmae_pkg::DATA_W-1:0] out_val_q, sat_val;
  logic                        out_last_q, out_err_q;
  logic [SAT_W-1:0]            top_bits;

  // stores: one write port (loads), one registered read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.we_a) begin
      a_mem[cmd_i.wr_addr] <= wr_data_i;
    end
    if (cmd_i.we_b) begin
      b_mem[cmd_i.wr_addr] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= a_mem[cmd_i.a_addr];
      b_rd_q <= b_mem[cmd_i.b_addr];
    end
  end

  // add terms are aligned to the Q32.32 product scale
  assign prod = mmae_pkg::PROD_W'(a_rd_q) * mmae_pkg::PROD_W'(b_rd_q);
  assign sum  = (mmae_pkg::DATA_W+1)'(a_rd_q) + (mmae_pkg::DATA_W+1)'(b_rd_q);
  always_comb begin
    if (cmd_i.is_add) begin
      term_d = mmae_pkg::ACC_W'(sum) <<< mmae_pkg::FRAC_W;
    end else begin
      term_d = mmae_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      term_q <= term_d;
    end
    if (s2_vld_q) begin
      acc_q <= (s2_first_q ? '0 : acc_q) + term_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.rd_en;
      s1_first_q <= cmd_i.first;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
    end
  end

  // floor to Q16.16, saturate when the upper bits are not all sign
  assign top_bits = acc_q[mmae_pkg::ACC_W-1 -: SAT_W];
  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      sat_val = acc_q[mmae_pkg::FRAC_W +: mmae_pkg::DATA_W];
    end else if (acc_q[mmae_pkg::ACC_W-1]) begin
      sat_val = {1'b1, {(mmae_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(mmae_pkg::DATA_W-1){1'b1}}};
    end
  end

  assign sts_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_q  <= cmd_i.out_err ? '0 : cmd_i.out_row;
      out_col_q  <= cmd_i.out_err ? '0 : cmd_i.out_col;
      out_val_q  <= cmd_i.out_err ? '0 : sat_val;
      out_last_q <= cmd_i.out_last;
      out_err_q  <= cmd_i.out_err;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_value_o  = out_val_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_err_q;

endmodule

// File: hdl/matrix_multiply_add_engine_top.sv
// channel   | dir | handshake                      | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata: row, col, value; tuser: func
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: row, col, value; tlast; tuser: status
// cfg       | in  | cfg_we_i                       | cfg_idx_i, cfg_data_i
//
// Loads are accepted back to back.
// Multiply: each result takes one store read per term, then passes the multiply and
// accumulate stages, then one emit step; add: a single store read, then the same path.
// A shape error skips the stores and gives its single item through the emit step.
// Input is held off while a command runs; output stalls hold the emit step.
// Reset clears control registers and sets dimension registers to 8; stores are not cleared.
module matrix_multiply_add_engine_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [mmae_pkg::DIM_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] row_index, [5:3] col_index, [37:6] element_value, [39:38] zero
  input  logic [mmae_pkg::TDATA_W-1:0]        s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] out_row, [5:3] out_col, [37:6] out_value, [39:38] zero
  output logic [mmae_pkg::TDATA_W-1:0]        m_axis_tdata,
  output logic                                m_axis_tlast,
  // [0] status
  output logic                                m_axis_tuser
);

  mmae_pkg::ctl_cmd_t cmd;
  mmae_pkg::dp_sts_t  sts;

  logic [mmae_pkg::IDX_W-1:0]  out_row, out_col;
  logic [mmae_pkg::DATA_W-1:0] out_value;

  mmae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser),
    .in_row_i   (s_axis_tdata[2:0]),
    .in_col_i   (s_axis_tdata[5:3]),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmae_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .wr_data_i    (s_axis_tdata[37:6]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};

`ifndef SYNTHESIS
  // result register is only loaded when it is empty or being drained
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten");

  // no input is taken while the stores are being walked
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !s_axis_tready)
    else $error("input accepted during compute");

  // an error result is always the only and final item of its command
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("error item not marked last or not zero");
`endif

endmodule
